/* sv/smc_pkg.sv */
// ----------------------------------------------------------------------------
// smc_pkg: shared types, codes and helper functions of the stack machine core
// Item codes, instruction opcodes, sequencer states, latency table and ALU.
// ----------------------------------------------------------------------------
`default_nettype none

package smc_pkg;

	localparam int unsigned STACK_DEPTH_DEF = 128;
	localparam int unsigned MEM_WORDS_DEF   = 65536;

	localparam int unsigned WORD_W  = 16;
	localparam int unsigned SPOUT_W = 7;

	// item codes on the input channel
	localparam logic [1:0] ITEM_TICK = 2'd0;
	localparam logic [1:0] ITEM_WR   = 2'd1;
	localparam logic [1:0] ITEM_RD   = 2'd2;

	// instruction opcodes (full word as stored in memory)
	localparam logic [15:0] OPC_PUSH  = 16'd0;
	localparam logic [15:0] OPC_POP   = 16'd1;
	localparam logic [15:0] OPC_HALT  = 16'd2;
	localparam logic [15:0] OPC_ADD   = 16'd3;
	localparam logic [15:0] OPC_SUB   = 16'd4;
	localparam logic [15:0] OPC_MUL   = 16'd5;
	localparam logic [15:0] OPC_AND   = 16'd6;
	localparam logic [15:0] OPC_OR    = 16'd7;
	localparam logic [15:0] OPC_XOR   = 16'd8;
	localparam logic [15:0] OPC_SHL   = 16'd9;
	localparam logic [15:0] OPC_SHR   = 16'd10;
	localparam logic [15:0] OPC_JMP   = 16'd11;
	localparam logic [15:0] OPC_CJMP  = 16'd12;
	localparam logic [15:0] OPC_LOAD  = 16'd13;
	localparam logic [15:0] OPC_STORE = 16'd14;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_DECODE = 5'b00010,
		ST_OPND   = 5'b00100,
		ST_EXEC   = 5'b01000,
		ST_READ   = 5'b10000
	} state_t;

	typedef struct packed {
		logic [15:0] mem_data;
		logic [15:0] mem_addr;
		logic [1:0]  op;
	} item_t;

	typedef struct packed {
		logic [15:0]        read_word;
		logic               retired;
		logic               halted;
		logic [15:0]        popped_value;
		logic [SPOUT_W-1:0] stack_ptr;
		logic [15:0]        prog_counter;
	} result_t;

	// ticks an opcode waits before it runs; zero for halt and unknown codes
	function automatic logic [2:0] latency_f(input logic [15:0] opc);
		logic [2:0] lat;
		case (opc) inside
			OPC_PUSH, OPC_POP:    lat = 3'd1;
			[OPC_ADD:OPC_SHR]:    lat = 3'd4;
			OPC_JMP:              lat = 3'd2;
			OPC_CJMP:             lat = 3'd4;
			OPC_LOAD, OPC_STORE:  lat = 3'd5;
			default:              lat = 3'd0;
		endcase
		return lat;
	endfunction

	// S op T, low 16 bits kept; shifts of 16 or more give zero
	function automatic logic [15:0] alu_f(input logic [15:0] opc,
			input logic [15:0] s, input logic [15:0] t);
		logic [31:0] prod;
		logic [15:0] res;
		logic        big;
		prod = s * t;
		big  = (t[15:4] != 12'd0);
		case (opc)
			OPC_ADD: res = s + t;
			OPC_SUB: res = s - t;
			OPC_MUL: res = prod[15:0];
			OPC_AND: res = s & t;
			OPC_OR:  res = s | t;
			OPC_XOR: res = s ^ t;
			OPC_SHL: res = big ? 16'd0 : (s << t[3:0]);
			OPC_SHR: res = big ? 16'd0 : (s >> t[3:0]);
			default: res = 16'd0;
		endcase
		return res;
	endfunction

endpackage

`default_nettype wire

/* sv/smc_ram.sv */
// ----------------------------------------------------------------------------
// smc_ram: generic single-clock RAM
// One write port, one read port, registered read data held while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module smc_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 256,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0]      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* sv/smc_in_buf.sv */
// ----------------------------------------------------------------------------
// smc_in_buf: one-entry input buffer
// Hold the next item while the sequencer still works on the current one.
// ----------------------------------------------------------------------------
`default_nettype none

module smc_in_buf (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire smc_pkg::item_t in_item,
	output logic               item_valid,
	output smc_pkg::item_t     item,
	input  wire logic          item_pop
);
	import smc_pkg::*;

	logic  buf_valid_q;
	item_t buf_q;

	assign in_ready   = !buf_valid_q || item_pop;
	assign item_valid = buf_valid_q;
	assign item       = buf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_valid_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			buf_valid_q <= 1'b1;
		end else if (item_pop) begin
			buf_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			buf_q <= in_item;
		end
	end

endmodule

`default_nettype wire

/* sv/smc_ctrl.sv */
// ----------------------------------------------------------------------------
// smc_ctrl: sequencer, architectural registers and result register
// Fetch the opcode, count wait ticks, read operands, execute and write back.
// ----------------------------------------------------------------------------
`default_nettype none

module smc_ctrl #(
	parameter int unsigned STACK_DEPTH = smc_pkg::STACK_DEPTH_DEF,
	parameter int unsigned MEM_WORDS   = smc_pkg::MEM_WORDS_DEF,
	localparam int unsigned SP_W   = $clog2(STACK_DEPTH),
	localparam int unsigned MEM_AW = $clog2(MEM_WORDS)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	input  wire smc_pkg::item_t    item,
	output logic                   item_pop,
	output logic                   mem_we,
	output logic [MEM_AW-1:0]      mem_waddr,
	output logic [15:0]            mem_wdata,
	output logic                   mem_re,
	output logic [MEM_AW-1:0]      mem_raddr,
	input  wire logic [15:0]       mem_rdata,
	output logic                   stk_we,
	output logic [SP_W-1:0]        stk_waddr,
	output logic [15:0]            stk_wdata,
	output logic                   stk_re,
	output logic [SP_W-1:0]        stk_raddr,
	input  wire logic [15:0]       stk_rdata,
	output logic                   res_valid,
	input  wire logic              res_ready,
	output smc_pkg::result_t       res
);
	import smc_pkg::*;

	localparam logic [SP_W-1:0] SP_ONE = SP_W'(1);
	localparam logic [SP_W-1:0] SP_TWO = SP_W'(2);

	state_t          state_q, state_d;
	logic [15:0]     pc_q, pc_d;
	logic [SP_W-1:0] sp_q, sp_d;
	logic [15:0]     pop_q, pop_d;
	logic            halt_q, halt_d;
	logic [2:0]      wait_q, wait_d;
	logic [15:0]     opc_q;
	logic [15:0]     imm_q;
	logic [15:0]     t_q;
	logic            res_valid_q;
	result_t         res_q;

	logic            out_free;
	logic            finish;
	logic            opc_ld;
	logic            retired_d;
	logic [15:0]     rword_d;
	logic [2:0]      wait_nx;
	logic [2:0]      lat;
	logic [15:0]     pc_p1;
	logic [15:0]     pc_p2;
	logic [SP_W-1:0] sp_p1;
	logic [SP_W-1:0] sp_m1;
	logic [SP_W-1:0] sp_m2;

	assign out_free  = !res_valid_q || res_ready;
	assign wait_nx   = wait_q + 3'd1;
	assign lat       = latency_f(mem_rdata);
	assign pc_p1     = pc_q + 16'd1;
	assign pc_p2     = pc_q + 16'd2;
	assign sp_p1     = sp_q + SP_ONE;
	assign sp_m1     = sp_q - SP_ONE;
	assign sp_m2     = sp_q - SP_TWO;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_comb begin
		state_d   = state_q;
		pc_d      = pc_q;
		sp_d      = sp_q;
		pop_d     = pop_q;
		halt_d    = halt_q;
		wait_d    = wait_q;
		opc_ld    = 1'b0;
		finish    = 1'b0;
		retired_d = 1'b0;
		rword_d   = 16'd0;
		item_pop  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = item.mem_addr[MEM_AW-1:0];
		mem_wdata = item.mem_data;
		mem_re    = 1'b0;
		mem_raddr = pc_q[MEM_AW-1:0];
		stk_we    = 1'b0;
		stk_waddr = sp_q;
		stk_wdata = imm_q;
		stk_re    = 1'b0;
		stk_raddr = sp_m1;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					case (item.op)
						ITEM_TICK: begin
							if (halt_q) begin
								if (out_free) begin
									finish   = 1'b1;
									item_pop = 1'b1;
								end
							end else begin
								mem_re   = 1'b1;
								item_pop = 1'b1;
								state_d  = ST_DECODE;
							end
						end
						ITEM_WR: begin
							if (out_free) begin
								mem_we   = 1'b1;
								finish   = 1'b1;
								item_pop = 1'b1;
							end
						end
						ITEM_RD: begin
							mem_re    = 1'b1;
							mem_raddr = item.mem_addr[MEM_AW-1:0];
							item_pop  = 1'b1;
							state_d   = ST_READ;
						end
						default: begin
							if (out_free) begin
								finish   = 1'b1;
								item_pop = 1'b1;
							end
						end
					endcase
				end
			end
			ST_DECODE: begin
				if (mem_rdata == OPC_HALT) begin
					if (out_free) begin
						finish    = 1'b1;
						retired_d = 1'b1;
						halt_d    = 1'b1;
						wait_d    = wait_nx;
						state_d   = ST_IDLE;
					end
				end else if (lat != 3'd0 && wait_nx == lat) begin
					wait_d    = 3'd0;
					opc_ld    = 1'b1;
					mem_re    = 1'b1;
					mem_raddr = pc_p1[MEM_AW-1:0];
					stk_re    = 1'b1;
					stk_raddr = sp_m1;
					state_d   = ST_OPND;
				end else if (out_free) begin
					finish  = 1'b1;
					wait_d  = wait_nx;
					state_d = ST_IDLE;
				end
			end
			ST_OPND: begin
				stk_re    = 1'b1;
				stk_raddr = sp_m2;
				mem_re    = 1'b1;
				mem_raddr = stk_rdata[MEM_AW-1:0];
				state_d   = ST_EXEC;
			end
			ST_EXEC: begin
				if (out_free) begin
					finish    = 1'b1;
					retired_d = 1'b1;
					state_d   = ST_IDLE;
					case (opc_q) inside
						OPC_PUSH: begin
							stk_we    = 1'b1;
							stk_waddr = sp_q;
							stk_wdata = imm_q;
							sp_d      = sp_p1;
							pc_d      = pc_p2;
						end
						OPC_POP: begin
							sp_d  = sp_m1;
							pop_d = t_q;
							pc_d  = pc_p1;
						end
						OPC_JMP: begin
							pc_d = pc_p1 + imm_q;
						end
						OPC_CJMP: begin
							sp_d = sp_m1;
							pc_d = (t_q != 16'd0) ? (pc_p1 + imm_q) : pc_p2;
						end
						OPC_LOAD: begin
							stk_we    = 1'b1;
							stk_waddr = sp_m1;
							stk_wdata = mem_rdata;
							pc_d      = pc_p1;
						end
						OPC_STORE: begin
							mem_we    = 1'b1;
							mem_waddr = t_q[MEM_AW-1:0];
							mem_wdata = stk_rdata;
							sp_d      = sp_m2;
							pc_d      = pc_p1;
						end
						[OPC_ADD:OPC_SHR]: begin
							stk_we    = 1'b1;
							stk_waddr = sp_m2;
							stk_wdata = alu_f(opc_q, stk_rdata, t_q);
							sp_d      = sp_m1;
							pc_d      = pc_p1;
						end
						default: begin
							retired_d = 1'b0;
						end
					endcase
				end
			end
			ST_READ: begin
				if (out_free) begin
					finish  = 1'b1;
					rword_d = mem_rdata;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pc_q        <= 16'd0;
			sp_q        <= '0;
			pop_q       <= 16'd0;
			halt_q      <= 1'b0;
			wait_q      <= 3'd0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pc_q    <= pc_d;
			sp_q    <= sp_d;
			pop_q   <= pop_d;
			halt_q  <= halt_d;
			wait_q  <= wait_d;
			if (finish) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (opc_ld) begin
			opc_q <= mem_rdata;
		end
		if (state_q == ST_OPND) begin
			imm_q <= mem_rdata;
			t_q   <= stk_rdata;
		end
		if (finish) begin
			res_q.prog_counter <= pc_d;
			res_q.stack_ptr    <= SPOUT_W'(sp_d);
			res_q.popped_value <= pop_d;
			res_q.halted       <= halt_d;
			res_q.retired      <= retired_d;
			res_q.read_word    <= rword_d;
		end
	end

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halt_q |=> halt_q)
		else $error("halt flag dropped");

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state not one-hot");

	a_mem_no_rw: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> !mem_re)
		else $error("memory read issued in a write cycle");

	a_opnd_after_decode: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OPND |-> $past(state_q) == ST_DECODE)
		else $error("operand fetch without decode");

	a_exec_wait_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EXEC |-> wait_q == 3'd0)
		else $error("wait counter not cleared at execute");

endmodule

`default_nettype wire

/* sv/stack_machine_core.sv */
// ----------------------------------------------------------------------------
// stack_machine_core: 16-bit stack machine stepped one tick per item
// Tick items advance the machine; write and read items reach main memory.
// ----------------------------------------------------------------------------
//
//  channel   dir  signals                    carries
//  --------  ---  -------------------------  ---------------------------------
//  s_*       in   s_tvalid s_tready s_tdata  item: op, mem_addr, mem_data
//  m_*       out  m_tvalid m_tready m_tdata  result: pc, sp, pop value, flags,
//                                            read word
//
//  A write item, a tick after halt or an unknown op finishes in the idle
//  state; a read item passes through the read state; a tick passes through
//  decode, and a tick that executes goes on through operand and execute.
//  The executing path is set by the serial reads of the synchronous RAMs:
//  opcode, then immediate and top of stack, then second entry and load word.
//  Reset (arst_n low) clears pc, sp, pop value, halt flag, wait counter and
//  both handshakes; main memory and the operand stack are not cleared.
//  A one-entry input buffer takes the next item while the current one runs;
//  the result register holds while m_tready is low and the sequencer waits.
//  MEM_WORDS and STACK_DEPTH must be powers of two.
//
`default_nettype none

module stack_machine_core #(
	parameter int unsigned STACK_DEPTH = smc_pkg::STACK_DEPTH_DEF,
	parameter int unsigned MEM_WORDS   = smc_pkg::MEM_WORDS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// [1:0] op, [17:2] mem_addr, [33:18] mem_data, [39:34] zero
	input  wire logic [39:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [15:0] prog_counter, [22:16] stack_ptr, [38:23] popped_value,
	// [39] halted, [40] retired, [56:41] read_word, [63:57] zero
	output logic [63:0]      m_tdata
);
	import smc_pkg::*;

	localparam int unsigned SP_W   = $clog2(STACK_DEPTH);
	localparam int unsigned MEM_AW = $clog2(MEM_WORDS);

	item_t             in_item;
	item_t             item;
	logic              item_valid;
	logic              item_pop;
	result_t           res;

	logic              mem_we;
	logic [MEM_AW-1:0] mem_waddr;
	logic [15:0]       mem_wdata;
	logic              mem_re;
	logic [MEM_AW-1:0] mem_raddr;
	logic [15:0]       mem_rdata;
	logic              stk_we;
	logic [SP_W-1:0]   stk_waddr;
	logic [15:0]       stk_wdata;
	logic              stk_re;
	logic [SP_W-1:0]   stk_raddr;
	logic [15:0]       stk_rdata;

	// unpack the item; pad bits are ignored
	assign in_item = s_tdata[33:0];
	// pack the result, pad with zeros to whole bytes
	assign m_tdata = {7'd0, res};

	// hold the next item while the sequencer is busy
	smc_in_buf u_in_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_item    (in_item),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop)
	);

	// main memory: program, immediates and load/store data
	smc_ram #(
		.WIDTH (16),
		.DEPTH (MEM_WORDS)
	) u_main_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// operand stack
	smc_ram #(
		.WIDTH (16),
		.DEPTH (STACK_DEPTH)
	) u_stack_mem (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.re    (stk_re),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	// sequencer: fetch, count, read operands, execute, write back
	smc_ctrl #(
		.STACK_DEPTH (STACK_DEPTH),
		.MEM_WORDS   (MEM_WORDS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_re     (mem_re),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata),
		.stk_we     (stk_we),
		.stk_waddr  (stk_waddr),
		.stk_wdata  (stk_wdata),
		.stk_re     (stk_re),
		.stk_raddr  (stk_raddr),
		.stk_rdata  (stk_rdata),
		.res_valid  (m_tvalid),
		.res_ready  (m_tready),
		.res        (res)
	);

endmodule

`default_nettype wire

/* tb/sv/tb_stack_machine_core.sv */
// ----------------------------------------------------------------------------
// tb_stack_machine_core: self-checking bench for the stack machine core
// Drives tick, memory write and memory read items, including the unused op
// code, with random gaps and long stalls on the result side. It predicts
// each result with its own model of the machine and memory, and checks every
// field of every result in order.
// ----------------------------------------------------------------------------

module tb_stack_machine_core;

	import smc_pkg::*;

	// op code 3 on the input channel is not used by the block
	localparam logic [1:0]  ITEM_NOP    = 2'd3;
	localparam logic [15:0] OPC_UNKNOWN = 16'hFFFF;

	localparam int RANDOM_ITEMS = 160;
	localparam int FILL_PUSHES  = STACK_DEPTH_DEF + 4;
	// pushes laid out in a row before the jump back of the fill loop
	localparam int PUSH_RUN     = 8;
	localparam int FILL_LOOPS   = (FILL_PUSHES + PUSH_RUN - 1) / PUSH_RUN;
	localparam int LONG_HOLD    = 300;
	localparam int DRAIN_CYCLES = 16;
	// About 420 items, each slowed by random send gaps, result stalls and its
	// time inside the block, plus the long hold.
	localparam int unsigned CYCLE_LIMIT = 500000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;   // [1:0] op, [17:2] mem_addr, [33:18] mem_data
	logic        m_tvalid;
	logic        m_tready;
	// [15:0] prog_counter, [22:16] stack_ptr, [38:23] popped_value,
	// [39] halted, [40] retired, [56:41] read_word
	logic [63:0] m_tdata;

	stack_machine_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// ------------------------------------------------------------------
	// Machine model: memory, operand stack and registers as the block
	// should hold them after every accepted item.
	// ------------------------------------------------------------------
	bit [15:0]         mach_mem  [0:65535];
	bit                mem_known [0:65535];
	bit [15:0]         mach_stk  [0:STACK_DEPTH_DEF-1];
	bit [15:0]         written_addrs [$];
	bit [15:0]         pc_q;
	bit [SPOUT_W-1:0]  sp_q;
	bit [15:0]         pop_q;
	bit                halt_q;
	bit [2:0]          wait_q;

	result_t     due_results [$];
	int          mismatches   = 0;
	int          items_sent   = 0;
	bit          last_retired;
	bit          tx_idle_on;
	bit          rx_idle_on;
	int          rx_hold_req  = 0;
	int unsigned cycle_count  = 0;

	function automatic bit [2:0] ticks_needed(input bit [15:0] opc);
		if (opc == OPC_PUSH || opc == OPC_POP)
			return 3'd1;
		if (opc >= OPC_ADD && opc <= OPC_SHR)
			return 3'd4;
		if (opc == OPC_JMP)
			return 3'd2;
		if (opc == OPC_CJMP)
			return 3'd4;
		if (opc == OPC_LOAD || opc == OPC_STORE)
			return 3'd5;
		return 3'd0;
	endfunction

	function automatic bit [15:0] alu_result(input bit [15:0] opc, input bit [15:0] s,
			input bit [15:0] t);
		case (opc)
			OPC_ADD: return s + t;
			OPC_SUB: return s - t;
			OPC_MUL: return s * t;
			OPC_AND: return s & t;
			OPC_OR:  return s | t;
			OPC_XOR: return s ^ t;
			OPC_SHL: return (t >= 16'd16) ? 16'd0 : (s << t);
			default: return (t >= 16'd16) ? 16'd0 : (s >> t);
		endcase
	endfunction

	function automatic void store_word(input bit [15:0] addr, input bit [15:0] data);
		mach_mem[addr]  = data;
		mem_known[addr] = 1'b1;
		written_addrs.push_back(addr);
	endfunction

	function automatic void execute_instr(input bit [15:0] opc);
		bit [15:0] top;
		bit [15:0] second;
		bit [15:0] imm;
		top    = mach_stk[sp_q - 7'd1];
		second = mach_stk[sp_q - 7'd2];
		imm    = mach_mem[pc_q + 16'd1];
		case (opc)
			OPC_PUSH: begin
				mach_stk[sp_q] = imm;
				sp_q = sp_q + 7'd1;
				pc_q = pc_q + 16'd2;
			end
			OPC_POP: begin
				sp_q  = sp_q - 7'd1;
				pop_q = mach_stk[sp_q];
				pc_q  = pc_q + 16'd1;
			end
			OPC_JMP: pc_q = pc_q + 16'd1 + imm;
			OPC_CJMP: begin
				// untaken branch still pops and steps over the offset word
				sp_q = sp_q - 7'd1;
				pc_q = (top != 16'd0) ? pc_q + 16'd1 + imm : pc_q + 16'd2;
			end
			OPC_LOAD: begin
				mach_stk[sp_q - 7'd1] = mach_mem[top];
				pc_q = pc_q + 16'd1;
			end
			OPC_STORE: begin
				store_word(top, second);
				sp_q = sp_q - 7'd2;
				pc_q = pc_q + 16'd1;
			end
			default: begin
				sp_q = sp_q - 7'd1;
				mach_stk[sp_q - 7'd1] = alu_result(opc, second, top);
				pc_q = pc_q + 16'd1;
			end
		endcase
	endfunction

	// advance the model by one item and return the result it must produce
	function automatic result_t step_machine(input bit [1:0] op, input bit [15:0] addr,
			input bit [15:0] data);
		result_t   r;
		bit [15:0] opc;
		bit [2:0]  need;
		r = '0;
		case (op)
			ITEM_TICK: if (!halt_q) begin
				opc    = mach_mem[pc_q];
				need   = ticks_needed(opc);
				wait_q = wait_q + 3'd1;
				if (opc == OPC_HALT) begin
					halt_q    = 1'b1;
					r.retired = 1'b1;
				end else if (need != 3'd0 && wait_q == need) begin
					wait_q = 3'd0;
					execute_instr(opc);
					r.retired = 1'b1;
				end
			end
			ITEM_WR: store_word(addr, data);
			ITEM_RD: r.read_word = mach_mem[addr];
			default: ;
		endcase
		r.prog_counter = pc_q;
		r.stack_ptr    = sp_q;
		r.popped_value = pop_q;
		r.halted       = halt_q;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Random helpers
	// ------------------------------------------------------------------
	// mostly back to back, some short gaps, a few long ones
	function automatic int idle_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// small values reach the shift boundary, extremes and full range the rest
	function automatic bit [15:0] operand_word();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return 16'($urandom_range(0, 20));
		if (r == 4)
			return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
		return 16'($urandom);
	endfunction

	// any defined opcode but halt
	function automatic bit [15:0] pick_opcode();
		bit [15:0] opc;
		opc = 16'($urandom_range(0, 13));
		if (opc >= OPC_HALT)
			opc = opc + 16'd1;
		return opc;
	endfunction

	// ------------------------------------------------------------------
	// Item driver: change inputs on the falling edge, predict on accept
	// ------------------------------------------------------------------
	task automatic send_item(input bit [1:0] op, input bit [15:0] addr, input bit [15:0] data);
		result_t want;
		int      gap;
		gap = tx_idle_on ? idle_gap() : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {6'd0, data, addr, op};
		do @(posedge clk); while (!s_tready);
		want = step_machine(op, addr, data);
		due_results.push_back(want);
		last_retired = want.retired;
		if (op != ITEM_NOP)
			items_sent++;
	endtask

	task automatic send_tick();
		send_item(ITEM_TICK, 16'($urandom), 16'($urandom));
	endtask

	// stop offering items until every result is back
	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
	endtask

	task automatic tick_until_retired();
		int guard;
		guard = 0;
		do begin
			send_tick();
			guard++;
		end while (!last_retired && guard < 16);
	endtask

	// place one instruction at pc and step the machine until it completes
	task automatic run_instr(input bit [15:0] opc, input bit [15:0] operand);
		bit [15:0] target;
		send_item(ITEM_WR, pc_q, opc);
		send_item(ITEM_WR, pc_q + 16'd1, operand);
		target = mach_stk[sp_q - 7'd1];
		// a load must find its address already written
		if (opc == OPC_LOAD && !mem_known[target])
			send_item(ITEM_WR, target, 16'($urandom));
		tick_until_retired();
	endtask

	// swap the opcode under pc while the machine waits on it, so the wait
	// counter may overshoot the new latency and wrap
	task automatic rewrite_while_waiting();
		bit [15:0] first_opc;
		bit [15:0] late_opc;
		case ($urandom_range(0, 3))
			0:       first_opc = OPC_STORE;
			1:       first_opc = OPC_LOAD;
			2:       first_opc = OPC_CJMP;
			default: first_opc = OPC_MUL;
		endcase
		case ($urandom_range(0, 4))
			0:       late_opc = OPC_PUSH;
			1:       late_opc = OPC_POP;
			2:       late_opc = OPC_JMP;
			3:       late_opc = OPC_SHR;
			default: late_opc = OPC_UNKNOWN;
		endcase
		send_item(ITEM_WR, pc_q, first_opc);
		send_item(ITEM_WR, pc_q + 16'd1, operand_word());
		repeat ($urandom_range(1, ticks_needed(first_opc) - 1)) send_tick();
		send_item(ITEM_WR, pc_q, late_opc);
		if (late_opc == OPC_UNKNOWN) begin
			repeat ($urandom_range(1, 3)) send_tick();
			send_item(ITEM_WR, pc_q, OPC_PUSH);
		end
		tick_until_retired();
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	// extreme addresses and data, read back, and the unused item code
	task automatic test_memory_items();
		send_item(ITEM_WR, 16'hFFFF, 16'hFFFF);
		send_item(ITEM_WR, 16'h0000, 16'h0000);
		send_item(ITEM_RD, 16'hFFFF, 16'h0000);
		send_item(ITEM_RD, 16'h0000, 16'hFFFF);
		send_item(ITEM_NOP, 16'hFFFF, 16'hFFFF);
	endtask

	// an unknown opcode stalls; replacing it late wraps the wait counter
	task automatic test_unknown_opcode_stall();
		send_item(ITEM_WR, pc_q, OPC_UNKNOWN);
		send_item(ITEM_WR, pc_q + 16'd1, 16'h8000);
		repeat (6) send_tick();
		send_item(ITEM_WR, pc_q, OPC_PUSH);
		tick_until_retired();
	endtask

	// backward jump whose offset sum wraps past 0xFFFF, then pop the pushed word
	task automatic test_jump_wrap_and_pop();
		run_instr(OPC_JMP, 16'hFFFE);
		run_instr(OPC_POP, operand_word());
	endtask

	// Loop "push imm" a few times in a row, then jump back, until the stack
	// pointer wraps, so every stack entry gets written. Hold the result side
	// off for a long stretch at the start while items keep coming, so the
	// block backs up.
	task automatic test_stack_fill();
		bit [15:0] base;
		int        k;
		int        n;
		base       = pc_q;
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		for (k = 0; k < PUSH_RUN; k++) begin
			send_item(ITEM_WR, base + 16'(2 * k), OPC_PUSH);
			send_item(ITEM_WR, base + 16'(2 * k + 1), operand_word());
		end
		send_item(ITEM_WR, base + 16'(2 * PUSH_RUN), OPC_JMP);
		send_item(ITEM_WR, base + 16'(2 * PUSH_RUN + 1), 16'(-(2 * PUSH_RUN + 1)));
		rx_hold_req = LONG_HOLD;
		for (n = 0; n < FILL_LOOPS * (PUSH_RUN + 2); n++) begin
			if (n == 40) begin
				tx_idle_on = 1'b1;
				rx_idle_on = 1'b1;
			end
			// vary the pushed values
			if ($urandom_range(0, 7) == 0)
				send_item(ITEM_WR,
					base + 16'(2 * $urandom_range(0, PUSH_RUN - 1) + 1),
					operand_word());
			send_tick();
		end
	endtask

	// well-formed instructions with random content, plus memory traffic,
	// late opcode rewrites and unused item codes
	task automatic test_random_programs();
		int          start;
		int unsigned pick;
		start = items_sent;
		while (items_sent - start < RANDOM_ITEMS) begin
			if ($urandom_range(0, 39) == 0)
				tx_idle_on = !tx_idle_on;
			if ($urandom_range(0, 39) == 0)
				rx_idle_on = !rx_idle_on;
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				run_instr(pick_opcode(), operand_word());
			end else if (pick < 66) begin
				// zero on top: the branch falls through
				run_instr(OPC_PUSH, 16'h0000);
				run_instr(OPC_CJMP, operand_word());
			end else if (pick < 76) begin
				send_item(ITEM_RD,
					written_addrs[$urandom_range(0, written_addrs.size() - 1)],
					16'($urandom));
			end else if (pick < 86) begin
				send_item(ITEM_WR, 16'($urandom), 16'($urandom));
			end else if (pick < 92) begin
				send_item(ITEM_NOP, 16'($urandom), 16'($urandom));
			end else begin
				rewrite_while_waiting();
			end
		end
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	// halt retires once, then ticks change nothing; memory stays reachable
	task automatic test_halt();
		bit [15:0] addr;
		drain_results();
		run_instr(OPC_HALT, operand_word());
		repeat (4) send_tick();
		addr = 16'($urandom);
		send_item(ITEM_WR, addr, 16'($urandom));
		send_tick();
		send_item(ITEM_RD, addr, 16'($urandom));
	endtask

	// ------------------------------------------------------------------
	// Result side: random stalls, plus a long hold on request
	// ------------------------------------------------------------------
	initial begin : result_sink
		int stall_left;
		stall_left = 0;
		m_tready   = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_req != 0) begin
				stall_left  = rx_hold_req;
				rx_hold_req = 0;
			end else if (stall_left == 0 && rx_idle_on && $urandom_range(0, 3) == 0) begin
				stall_left = idle_gap();
			end
			if (stall_left != 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	function automatic void check_field(input string name, input logic [15:0] want,
			input logic [15:0] seen);
		if (seen !== want) begin
			$display("%0t: %s expected %h actual %h", $time, name, want, seen);
			mismatches++;
		end
	endfunction

	// compare each accepted result with the oldest prediction
	always @(posedge clk) begin
		result_t want;
		result_t seen;
		if (arst_n === 1'b1 && m_tvalid === 1'b1 && m_tready) begin
			if (due_results.size() == 0) begin
				$display("%0t: result with nothing expected, actual %h", $time, m_tdata);
				mismatches++;
			end else begin
				want = due_results.pop_front();
				seen = m_tdata[56:0];
				check_field("prog_counter", want.prog_counter, seen.prog_counter);
				check_field("stack_ptr", 16'(want.stack_ptr), 16'(seen.stack_ptr));
				check_field("popped_value", want.popped_value, seen.popped_value);
				check_field("halted", 16'(want.halted), 16'(seen.halted));
				check_field("retired", 16'(want.retired), 16'(seen.retired));
				check_field("read_word", want.read_word, seen.read_word);
				check_field("tdata padding", 16'd0, 16'(m_tdata[63:57]));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_memory_items();
		test_unknown_opcode_stall();
		test_jump_wrap_and_pop();
		test_stack_fill();
		drain_results();
		test_random_programs();
		test_halt();

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

/* files.f */
sv/smc_pkg.sv
sv/smc_ram.sv
sv/smc_in_buf.sv
sv/smc_ctrl.sv
sv/stack_machine_core.sv
tb/sv/tb_stack_machine_core.sv
